@@ rtl/plct_pkg.sv @@
// Shared types and constants for the phone line call state table.
// Holds the line state codes, event codes, table entry and result beat layouts.
// No dependencies.
package plct_pkg;

  localparam int unsigned LINE_W    = 6;
  localparam int unsigned NUM_LINES = 1 << LINE_W;

  typedef enum logic [2:0] {
    ST_ON_HOOK   = 3'd0,
    ST_RINGING   = 3'd1,
    ST_DIAL_TONE = 3'd2,
    ST_RING_BACK = 3'd3,
    ST_BUSY      = 3'd4,
    ST_CONNECTED = 3'd5,
    ST_ERROR     = 3'd6
  } line_state_e;

  typedef enum logic [1:0] {
    FN_DIAL   = 2'd0,
    FN_PICKUP = 2'd1,
    FN_HANGUP = 2'd2,
    FN_CHAT   = 2'd3
  } func_e;

  // One table entry; all-zero is the reset value (on hook, no peer).
  typedef struct packed {
    line_state_e       state;
    logic [LINE_W-1:0] peer;
    logic              pvalid;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [LINE_W-1:0] line;
    logic              kind;
    line_state_e       code;
    logic [LINE_W-1:0] peer;
    logic              failed;
    logic              last;
  } res_t;

  // Event decision handed from the event logic to the sequencer.
  typedef struct packed {
    entry_t new_a;
    entry_t new_b;
    logic   wr_b;
    logic   two;
    res_t   r0;
    res_t   r1;
  } ev_out_t;

endpackage

@@ rtl/phone_line_call_state_table.sv @@
// Phone line call state table, top level.
// Uses plct_pkg, plct_ram (line table) and plct_event (event decisions).
//
// Input channel: one beat is one call event (func, line, target_line,
// target_known), taken when in_valid_i is high and in_stall_o is low.
// Output channel: each event gives one or two beats; the final one has
// last_o set. A beat is taken when out_valid_o is high and out_stall_i low.
// The line table is a 64-entry RAM with registered read, so an event
// is handled as: read originating line, read target or peer line, decide and
// write the originating line, then write the second line when it changed.
// The second write happens only when two lines are updated. The first result
// beat is shown once the decide step loads it into the output buffer.
// Results sit in a two-beat output buffer; the block takes the next event while
// they wait, and holds at the decide step until the buffer has drained.
// A stalled output beat holds its value.
// Reset puts every line on hook with no peer: per-entry written flags are
// cleared, and an entry never written reads as that reset value.
module phone_line_call_state_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  func_i,
  input  logic [plct_pkg::LINE_W-1:0] line_i,
  input  logic [plct_pkg::LINE_W-1:0] target_line_i,
  input  logic                        target_known_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [plct_pkg::LINE_W-1:0] notify_line_o,
  output logic                        kind_o,
  output logic [2:0]                  line_state_code_o,
  output logic [plct_pkg::LINE_W-1:0] peer_shown_o,
  output logic                        failed_o,
  output logic                        last_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDA,
    S_RDB,
    S_CALC,
    S_WRB
  } seq_e;

  seq_e                        state_q;
  plct_pkg::func_e             func_q;
  logic [plct_pkg::LINE_W-1:0] line_q, tgt_q, addr_b_q;
  logic                        known_q;
  plct_pkg::entry_t            ent_a_q, new_b_q;
  logic [plct_pkg::NUM_LINES-1:0] written_q;
  logic                        rd_ok_q;

  plct_pkg::res_t              out_q [2];
  logic [1:0]                  cnt_q;

  logic                         ram_we, ram_re;
  logic [plct_pkg::LINE_W-1:0]  ram_waddr, ram_raddr;
  logic [plct_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
  plct_pkg::entry_t            rd_ent;
  plct_pkg::ev_out_t           ev;
  logic                        pop, load;

  plct_ram #(
    .WIDTH(plct_pkg::ENTRY_W),
    .DEPTH(plct_pkg::NUM_LINES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // never-written entries read as on hook, no peer
  assign rd_ent = rd_ok_q ? plct_pkg::entry_t'(ram_rdata) : '0;

  plct_event u_event (
    .func_i        (func_q),
    .line_i        (line_q),
    .target_line_i (tgt_q),
    .target_known_i(known_q),
    .ent_a_i       (ent_a_q),
    .ent_b_i       (rd_ent),
    .ev_o          (ev)
  );

  assign load = (state_q == S_CALC) && (cnt_q == 2'd0);
  assign pop  = out_valid_o && !out_stall_i;

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = line_q;
    ram_we    = 1'b0;
    ram_waddr = line_q;
    ram_wdata = ev.new_a;
    unique case (state_q)
      S_RDA: ram_re = 1'b1;
      S_RDB: begin
        ram_re    = 1'b1;
        ram_raddr = (func_q == plct_pkg::FN_DIAL) ? tgt_q : rd_ent.peer;
      end
      S_CALC: ram_we = load;
      S_WRB: begin
        ram_we    = 1'b1;
        ram_waddr = addr_b_q;
        ram_wdata = new_b_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      written_q <= '0;
      cnt_q     <= 2'd0;
      rd_ok_q   <= 1'b0;
    end else begin
      if (ram_re) begin
        rd_ok_q <= written_q[ram_raddr];
      end
      if (ram_we) begin
        written_q[ram_waddr] <= 1'b1;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            func_q  <= plct_pkg::func_e'(func_i);
            line_q  <= line_i;
            tgt_q   <= target_line_i;
            known_q <= target_known_i;
            state_q <= S_RDA;
          end
        end
        S_RDA: state_q <= S_RDB;
        S_RDB: begin
          ent_a_q  <= rd_ent;
          addr_b_q <= ram_raddr;
          state_q  <= S_CALC;
        end
        S_CALC: begin
          if (load) begin
            new_b_q <= ev.new_b;
            state_q <= ev.wr_b ? S_WRB : S_IDLE;
          end
        end
        S_WRB: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
      // output buffer: loads only when empty, so load and pop never coincide
      if (load) begin
        out_q[0] <= ev.r0;
        out_q[1] <= ev.r1;
        cnt_q    <= ev.two ? 2'd2 : 2'd1;
      end else if (pop) begin
        out_q[0] <= out_q[1];
        cnt_q    <= cnt_q - 2'd1;
      end
    end
  end

  assign in_stall_o        = (state_q != S_IDLE);
  assign out_valid_o       = (cnt_q != 2'd0);
  assign notify_line_o     = out_q[0].line;
  assign kind_o            = out_q[0].kind;
  assign line_state_code_o = 3'(out_q[0].code);
  assign peer_shown_o      = out_q[0].peer;
  assign failed_o          = out_q[0].failed;
  assign last_o            = out_q[0].last;

endmodule

@@ rtl/plct_ram.sv @@
// Generic synchronous RAM: one write port, one read port, registered read data.
// No dependencies.
module plct_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/plct_event.sv @@
// Event decision logic: from the originating line's entry and the second entry
// (dial target or current peer) works out the new entries and result beats.
// Depends on plct_pkg.
module plct_event (
  input  plct_pkg::func_e              func_i,
  input  logic [plct_pkg::LINE_W-1:0]  line_i,
  input  logic [plct_pkg::LINE_W-1:0]  target_line_i,
  input  logic                         target_known_i,
  input  plct_pkg::entry_t             ent_a_i,
  input  plct_pkg::entry_t             ent_b_i,
  output plct_pkg::ev_out_t            ev_o
);

  // State notification: peer shown only when connected with a live link.
  function automatic plct_pkg::res_t notify(logic [plct_pkg::LINE_W-1:0] ln,
                                            plct_pkg::entry_t e,
                                            logic failed, logic last);
    plct_pkg::res_t r;
    r.line   = ln;
    r.kind   = 1'b0;
    r.code   = e.state;
    r.peer   = (e.state == plct_pkg::ST_CONNECTED && e.pvalid) ? e.peer : '0;
    r.failed = failed;
    r.last   = last;
    return r;
  endfunction

  always_comb begin
    ev_o       = '0;
    ev_o.new_a = ent_a_i;
    ev_o.new_b = ent_b_i;
    unique case (func_i)
      plct_pkg::FN_DIAL: begin
        if (ent_a_i.state != plct_pkg::ST_DIAL_TONE) begin
          ev_o.r0 = notify(line_i, ent_a_i, 1'b0, 1'b1);
        end else if (!target_known_i) begin
          ev_o.new_a.state = plct_pkg::ST_ERROR;
          ev_o.r0 = notify(line_i, ev_o.new_a, 1'b0, 1'b1);
        end else if (target_line_i == line_i || ent_b_i.pvalid ||
                     ent_b_i.state != plct_pkg::ST_ON_HOOK) begin
          ev_o.new_a.state = plct_pkg::ST_BUSY;
          ev_o.r0 = notify(line_i, ev_o.new_a, 1'b0, 1'b1);
        end else begin
          ev_o.new_a = '{state: plct_pkg::ST_RING_BACK, peer: target_line_i,
                         pvalid: 1'b1};
          ev_o.new_b = '{state: plct_pkg::ST_RINGING, peer: line_i, pvalid: 1'b1};
          ev_o.wr_b  = 1'b1;
          ev_o.two   = 1'b1;
          ev_o.r0 = notify(line_i, ev_o.new_a, 1'b0, 1'b0);
          ev_o.r1 = notify(target_line_i, ev_o.new_b, 1'b0, 1'b1);
        end
      end
      plct_pkg::FN_PICKUP: begin
        if (ent_a_i.state == plct_pkg::ST_ON_HOOK) begin
          ev_o.new_a.state = plct_pkg::ST_DIAL_TONE;
          ev_o.r0 = notify(line_i, ev_o.new_a, 1'b0, 1'b1);
        end else if (ent_a_i.state == plct_pkg::ST_RINGING && ent_a_i.pvalid) begin
          ev_o.new_a.state = plct_pkg::ST_CONNECTED;
          ev_o.new_b.state = plct_pkg::ST_CONNECTED;
          ev_o.wr_b = 1'b1;
          ev_o.two  = 1'b1;
          ev_o.r0 = notify(line_i, ev_o.new_a, 1'b0, 1'b0);
          ev_o.r1 = notify(ent_a_i.peer, ev_o.new_b, 1'b0, 1'b1);
        end else begin
          ev_o.r0 = notify(line_i, ent_a_i, 1'b0, 1'b1);
        end
      end
      plct_pkg::FN_HANGUP: begin
        ev_o.new_a.state = plct_pkg::ST_ON_HOOK;
        if (ent_a_i.pvalid && (ent_a_i.state == plct_pkg::ST_CONNECTED ||
                               ent_a_i.state == plct_pkg::ST_RINGING ||
                               ent_a_i.state == plct_pkg::ST_RING_BACK)) begin
          ev_o.new_a = '0;
          ev_o.new_b = '0;
          ev_o.new_b.state = (ent_a_i.state == plct_pkg::ST_RING_BACK) ?
                             plct_pkg::ST_ON_HOOK : plct_pkg::ST_DIAL_TONE;
          ev_o.wr_b = 1'b1;
          ev_o.two  = 1'b1;
          ev_o.r0 = notify(line_i, ev_o.new_a, 1'b0, 1'b0);
          ev_o.r1 = notify(ent_a_i.peer, ev_o.new_b, 1'b0, 1'b1);
        end else begin
          ev_o.r0 = notify(line_i, ev_o.new_a, 1'b0, 1'b1);
        end
      end
      plct_pkg::FN_CHAT: begin
        if (ent_a_i.state == plct_pkg::ST_CONNECTED && ent_a_i.pvalid) begin
          ev_o.two = 1'b1;
          ev_o.r0  = '{line: ent_a_i.peer, kind: 1'b1, code: ent_b_i.state,
                       peer: line_i, failed: 1'b0, last: 1'b0};
          ev_o.r1  = notify(line_i, ent_a_i, 1'b0, 1'b1);
        end else begin
          ev_o.r0 = notify(line_i, ent_a_i, 1'b1, 1'b1);
        end
      end
      default: ev_o.r0 = notify(line_i, ent_a_i, 1'b0, 1'b1);
    endcase
  end

endmodule

@@ rtl/plct_checker.sv @@
// Port-level checks for the phone line call state table, bound to the top.
// Depends on plct_pkg and phone_line_call_state_table.
module plct_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [plct_pkg::LINE_W-1:0] notify_line_o,
  input logic                        kind_o,
  input logic [2:0]                  line_state_code_o,
  input logic [plct_pkg::LINE_W-1:0] peer_shown_o,
  input logic                        failed_o,
  input logic                        last_o
);

  // stalled output beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(notify_line_o) &&
      $stable(kind_o) && $stable(line_state_code_o) && $stable(peer_shown_o) &&
      $stable(failed_o) && $stable(last_o))
    else $error("stalled output beat changed");

  // one event at a time: an accepted beat closes the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input open right after accept");

  // a chat delivery is always followed by the sender's notification
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o |-> !last_o && !failed_o)
    else $error("chat delivery marked last or failed");

  // a refused chat is a lone state notification
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && failed_o |-> last_o && !kind_o)
    else $error("refused chat beat malformed");

endmodule

bind phone_line_call_state_table plct_checker u_plct_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .notify_line_o    (notify_line_o),
  .kind_o           (kind_o),
  .line_state_code_o(line_state_code_o),
  .peer_shown_o     (peer_shown_o),
  .failed_o         (failed_o),
  .last_o           (last_o)
);
